// ===== hw/rtl/depthwise_causal_conv1d_defines.svh =====
// Assertion macros for the depthwise causal convolution block.
`ifndef DEPTHWISE_CAUSAL_CONV1D_DEFINES_SVH
`define DEPTHWISE_CAUSAL_CONV1D_DEFINES_SVH

// Checked only out of reset.
`define DCC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define DCC_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/dcc_pkg.sv =====
package dcc_pkg;

    localparam int CHANNELS_DEF = 256;
    localparam int MAX_TAPS_DEF = 4;

    localparam int DATA_W = 16;
    localparam int PROD_W = 2 * DATA_W;
    localparam int FRAC_W = 12;
    localparam int TAPS_CFG_W = 3;

    localparam logic [TAPS_CFG_W-1:0] TAPS_RESET = 3'd4;

    localparam logic [1:0] CMD_WRITE_COEF = 2'd0;
    localparam logic [1:0] CMD_PUSH_HIST  = 2'd1;
    localparam logic [1:0] CMD_COMPUTE    = 2'd2;

    localparam logic signed [DATA_W-1:0] Q_MAX = 16'sh7FFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 16'sh8000;

    typedef struct packed {
        logic [1:0]               command;
        logic [7:0]               channel;
        logic [1:0]               tap_index;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [7:0]               out_channel;
        logic signed [DATA_W-1:0] out_value;
        logic                     saturated;
    } out_item_t;

endpackage

// ===== hw/rtl/dcc_ram.sv =====
module dcc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/depthwise_causal_conv1d.sv =====
// Path: a compute transfer is registered in s1_item_reg, s2_prod_reg, s3_sum_reg and then out_data_reg.
// Throughput: one item per cycle while out is not stalled; set by the read-modify-write of a channel row
// in the coefficient RAM and the history RAM, with one-entry write forwarding on each.
// Reset: control and valids cleared, taps_reg set to 4; the RAMs are not cleared and
// need no pass, entries are undefined until written.
`include "depthwise_causal_conv1d_defines.svh"

module depthwise_causal_conv1d
    import dcc_pkg::*;
#(
    parameter int CHANNELS = CHANNELS_DEF,
    parameter int MAX_TAPS = MAX_TAPS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [TAPS_CFG_W-1:0] cfg_data
);

    localparam int CH_AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int HIST_LEN = MAX_TAPS - 1;
    localparam int IDX_W    = $clog2(MAX_TAPS);
    localparam int TAP_W    = $clog2(MAX_TAPS + 1);
    localparam int SUM_W    = PROD_W + $clog2(MAX_TAPS) + 1;
    localparam int CROW_W   = MAX_TAPS * DATA_W;
    localparam int HROW_W   = HIST_LEN * DATA_W;

    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1 <<< (FRAC_W - 1));
    localparam logic signed [SUM_W-1:0] SAT_HI     = SUM_W'(32'sd32767);
    localparam logic signed [SUM_W-1:0] SAT_LO     = SUM_W'(-32'sd32768);

    typedef logic [MAX_TAPS-1:0][DATA_W-1:0] crow_t;
    typedef logic [HIST_LEN-1:0][DATA_W-1:0] hrow_t;

    logic                  adv;
    logic                  in_xfer;
    logic [TAPS_CFG_W-1:0] taps_reg;
    logic [TAP_W-1:0]      taps_eff;

    // stage 1: rows read, modified, written back; products formed
    logic           s1_valid_reg;
    in_item_t       s1_item_reg;
    logic [CH_AW-1:0] s1_addr;
    logic           s1_ch_ok;
    logic           coef_we;
    logic           hist_we;
    logic [CROW_W-1:0] coef_rdata;
    logic [HROW_W-1:0] hist_rdata;
    crow_t          crow;
    crow_t          crow_new;
    hrow_t          hrow;
    hrow_t          hrow_new;

    logic           cf_valid_reg;
    logic [CH_AW-1:0] cf_addr_reg;
    crow_t          cf_row_reg;
    logic           hf_valid_reg;
    logic [CH_AW-1:0] hf_addr_reg;
    hrow_t          hf_row_reg;

    logic signed [DATA_W-1:0] ext [MAX_TAPS];
    logic [IDX_W-1:0]         off;
    logic signed [PROD_W-1:0] prod_next [MAX_TAPS];

    // stage 2: products
    logic                     s2_valid_reg;
    logic [7:0]               s2_channel_reg;
    logic signed [PROD_W-1:0] s2_prod_reg [MAX_TAPS];
    logic signed [SUM_W-1:0]  sum_next;

    // stage 3: sum
    logic                     s3_valid_reg;
    logic [7:0]               s3_channel_reg;
    logic signed [SUM_W-1:0]  s3_sum_reg;
    logic signed [SUM_W-1:0]  rounded;
    logic signed [SUM_W-1:0]  shifted;
    out_item_t                out_next;

    logic                     out_valid_reg;
    out_item_t                out_data_reg;

    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv;
    assign in_xfer   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taps_reg <= TAPS_RESET;
        end
        else if (cfg_valid)
        begin
            taps_reg <= cfg_data;
        end
    end

    always_comb
    begin
        if (taps_reg == '0)
        begin
            taps_eff = TAP_W'(1);
        end
        else if (32'(taps_reg) > MAX_TAPS)
        begin
            taps_eff = TAP_W'(MAX_TAPS);
        end
        else
        begin
            taps_eff = TAP_W'(taps_reg);
        end
    end

    dcc_ram #(
        .WIDTH (CROW_W),
        .DEPTH (CHANNELS)
    ) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .waddr (s1_addr),
        .wdata (crow_new),
        .re    (in_xfer),
        .raddr (CH_AW'(in_data.channel)),
        .rdata (coef_rdata)
    );

    dcc_ram #(
        .WIDTH (HROW_W),
        .DEPTH (CHANNELS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (hist_we),
        .waddr (s1_addr),
        .wdata (hrow_new),
        .re    (in_xfer),
        .raddr (CH_AW'(in_data.channel)),
        .rdata (hist_rdata)
    );

    assign s1_addr  = CH_AW'(s1_item_reg.channel);
    assign s1_ch_ok = 32'(s1_item_reg.channel) < CHANNELS;

    assign coef_we = adv && s1_valid_reg && s1_ch_ok
                     && (s1_item_reg.command == CMD_WRITE_COEF)
                     && (32'(s1_item_reg.tap_index) < MAX_TAPS);
    assign hist_we = adv && s1_valid_reg && s1_ch_ok
                     && ((s1_item_reg.command == CMD_PUSH_HIST)
                         || (s1_item_reg.command == CMD_COMPUTE));

    // a row written at the edge that read it comes from the forwarding register
    assign crow = (cf_valid_reg && cf_addr_reg == s1_addr) ? cf_row_reg : crow_t'(coef_rdata);
    assign hrow = (hf_valid_reg && hf_addr_reg == s1_addr) ? hf_row_reg : hrow_t'(hist_rdata);

    always_comb
    begin
        for (int i = 0; i < MAX_TAPS; i++)
        begin
            crow_new[i] = (32'(s1_item_reg.tap_index) == i) ? s1_item_reg.value : crow[i];
        end
        for (int i = 0; i < HIST_LEN - 1; i++)
        begin
            hrow_new[i] = hrow[i + 1];
        end
        hrow_new[HIST_LEN-1] = s1_item_reg.value;
    end

    // window: history oldest first, current sample last
    always_comb
    begin
        for (int k = 0; k < HIST_LEN; k++)
        begin
            ext[k] = $signed(hrow[k]);
        end
        ext[MAX_TAPS-1] = s1_item_reg.value;
        off = IDX_W'(MAX_TAPS - int'(taps_eff));
        for (int i = 0; i < MAX_TAPS; i++)
        begin
            if (int'(taps_eff) > i)
            begin
                prod_next[i] = PROD_W'($signed(crow[i])) * PROD_W'(ext[off + IDX_W'(i)]);
            end
            else
            begin
                prod_next[i] = '0;
            end
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int i = 0; i < MAX_TAPS; i++)
        begin
            sum_next = sum_next + SUM_W'(s2_prod_reg[i]);
        end
    end

    assign rounded = s3_sum_reg + ROUND_HALF;
    assign shifted = rounded >>> FRAC_W;

    always_comb
    begin
        out_next.out_channel = s3_channel_reg;
        out_next.saturated   = 1'b0;
        out_next.out_value   = shifted[DATA_W-1:0];
        if (shifted > SAT_HI)
        begin
            out_next.out_value = Q_MAX;
            out_next.saturated = 1'b1;
        end
        else if (shifted < SAT_LO)
        begin
            out_next.out_value = Q_MIN;
            out_next.saturated = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            cf_valid_reg  <= 1'b0;
            hf_valid_reg  <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                s1_valid_reg  <= in_xfer;
                s2_valid_reg  <= s1_valid_reg && s1_ch_ok
                                 && (s1_item_reg.command == CMD_COMPUTE);
                s3_valid_reg  <= s2_valid_reg;
                out_valid_reg <= s3_valid_reg;
            end
            if (coef_we)
            begin
                cf_valid_reg <= 1'b1;
            end
            if (hist_we)
            begin
                hf_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_item_reg    <= in_data;
            s2_channel_reg <= s1_item_reg.channel;
            s2_prod_reg    <= prod_next;
            s3_channel_reg <= s2_channel_reg;
            s3_sum_reg     <= sum_next;
            out_data_reg   <= out_next;
        end
        if (coef_we)
        begin
            cf_addr_reg <= s1_addr;
            cf_row_reg  <= crow_new;
        end
        if (hist_we)
        begin
            hf_addr_reg <= s1_addr;
            hf_row_reg  <= hrow_new;
        end
    end

    `DCC_ASSERT(a_sat_clips, (out_valid_reg && out_data_reg.saturated) |-> (out_data_reg.out_value == Q_MAX || out_data_reg.out_value == Q_MIN), "saturated result not at a rail")
    `DCC_ASSERT(a_s1_holds, (s1_valid_reg && !adv) |=> (s1_valid_reg && $stable(s1_item_reg)), "stage 1 moved during stall")
    `DCC_ASSERT(a_no_wr_bubble, (coef_we || hist_we) |-> (s1_valid_reg && s1_ch_ok), "RAM write without an item")
    `DCC_ASSERT_RST(a_rst_clear, !rst_n |=> (!out_valid_reg && !s1_valid_reg && !s2_valid_reg), "valid set in reset")

endmodule

// ===== dv/dcc_checker.sv =====
`timescale 1ns / 1ps

module dcc_checker
    import dcc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  in_item_t              in_data,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  out_item_t             out_data,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [TAPS_CFG_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    results_due
);

    localparam int HIST_DEPTH = MAX_TAPS_DEF - 1;
    localparam int PRINT_CAP = 200;

    logic signed [DATA_W-1:0] coef_row [CHANNELS_DEF][MAX_TAPS_DEF];
    logic signed [DATA_W-1:0] hist_row [CHANNELS_DEF][HIST_DEPTH];
    logic [TAPS_CFG_W-1:0]    taps_cfg;
    out_item_t                conv_due [$];

    // Oldest window sample meets tap 0, the current sample meets tap taps-1.
    function automatic out_item_t fir_output(input logic [7:0] ch,
                                             input logic signed [DATA_W-1:0] sample);
        int        taps;
        int        i;
        longint    acc;
        longint    q;
        out_item_t o;
        if (taps_cfg == 0)
            taps = 1;
        else if (taps_cfg > MAX_TAPS_DEF)
            taps = MAX_TAPS_DEF;
        else
            taps = int'(taps_cfg);
        acc = 0;
        for (i = 0; i < taps - 1; i++)
            acc += longint'(hist_row[ch][HIST_DEPTH - (taps - 1) + i]) *
                   longint'(coef_row[ch][i]);
        acc += longint'(sample) * longint'(coef_row[ch][taps - 1]);
        q = (acc + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
        o.out_channel = ch;
        o.saturated = 1'b0;
        if (q > longint'(Q_MAX))
        begin
            o.out_value = Q_MAX;
            o.saturated = 1'b1;
        end
        else if (q < longint'(Q_MIN))
        begin
            o.out_value = Q_MIN;
            o.saturated = 1'b1;
        end
        else
        begin
            o.out_value = DATA_W'(q);
        end
        return o;
    endfunction

    function automatic void push_sample(input logic [7:0] ch,
                                        input logic signed [DATA_W-1:0] sample);
        int i;
        for (i = 0; i < HIST_DEPTH - 1; i++)
            hist_row[ch][i] = hist_row[ch][i + 1];
        hist_row[ch][HIST_DEPTH - 1] = sample;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        out_item_t want;
        if (!rst_n)
        begin
            taps_cfg = TAPS_RESET;
            conv_due.delete();
            fail_count = 0;
            results_due = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                taps_cfg = cfg_data;
            if (in_valid && in_ready)
            begin
                case (in_data.command)
                    CMD_WRITE_COEF:
                    begin
                        coef_row[in_data.channel][in_data.tap_index] = in_data.value;
                    end
                    CMD_PUSH_HIST:
                    begin
                        push_sample(in_data.channel, in_data.value);
                    end
                    CMD_COMPUTE:
                    begin
                        conv_due.push_back(fir_output(in_data.channel, in_data.value));
                        push_sample(in_data.channel, in_data.value);
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (conv_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= PRINT_CAP)
                        $display("%0t: unexpected result, expected none, actual ch %0d value %0d sat %0b",
                                 $time, out_data.out_channel, out_data.out_value,
                                 out_data.saturated);
                end
                else
                begin
                    want = conv_due.pop_front();
                    if (out_data.out_channel !== want.out_channel ||
                        out_data.out_value !== want.out_value ||
                        out_data.saturated !== want.saturated)
                    begin
                        fail_count++;
                        if (fail_count <= PRINT_CAP)
                            $display("%0t: expected ch %0d value %0d sat %0b, actual ch %0d value %0d sat %0b",
                                     $time, want.out_channel, want.out_value, want.saturated,
                                     out_data.out_channel, out_data.out_value,
                                     out_data.saturated);
                    end
                end
            end
            results_due = conv_due.size();
        end
    end

endmodule

// ===== dv/tb_depthwise_causal_conv1d.sv =====
`timescale 1ns / 1ps

module tb_depthwise_causal_conv1d;
    import dcc_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int HIST_DEPTH = MAX_TAPS_DEF - 1;
    localparam int SEG_ITEMS = 310;
    localparam int NUM_SEGS = 6;
    localparam int STALL_LIMIT = 2000;
    localparam int FLUSH_CYCLES = 8;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [TAPS_CFG_W-1:0] cfg_data;

    int fail_count;
    int results_due;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int quiet_cycles = 0;
    int items_sent = 0;
    int seg_taps [NUM_SEGS] = '{1, 7, 0, 3, 2, 4};
    bit coef_set [CHANNELS_DEF][MAX_TAPS_DEF];
    int hist_fill [CHANNELS_DEF];

    depthwise_causal_conv1d dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    dcc_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .results_due (results_due)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic signed [DATA_W-1:0] rand_q();
        int v;
        case ($urandom_range(0, 3))
            0: return DATA_W'($urandom);
            1:
            begin
                v = $urandom_range(0, 8192);
                return DATA_W'(v - 4096);
            end
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default:
            begin
                v = $urandom_range(0, 32768);
                return DATA_W'(v - 16384);
            end
        endcase
    endfunction

    // Mostly a small pool of channels so that their rows get reused.
    function automatic logic [7:0] pick_channel();
        if ($urandom_range(0, 3) != 0)
            return 8'($urandom_range(0, 15) * 17);
        return 8'($urandom_range(0, 255));
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] ch,
                             input logic [1:0] tap, input logic signed [DATA_W-1:0] val);
        in_item_t it;
        it.command = cmd;
        it.channel = ch;
        it.tap_index = tap;
        it.value = val;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        case (cmd)
            CMD_WRITE_COEF:
            begin
                coef_set[ch][tap] = 1'b1;
            end
            CMD_PUSH_HIST, CMD_COMPUTE:
            begin
                if (hist_fill[ch] < HIST_DEPTH)
                    hist_fill[ch]++;
            end
            default:
            begin
            end
        endcase
        if (cmd != CMD_UNUSED)
            items_sent++;
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (results_due != 0);
    endtask

    task automatic write_taps(input logic [TAPS_CFG_W-1:0] taps);
        hold_until_drained();
        repeat (FLUSH_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= taps;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // A compute never reads a coefficient or history entry that was not written.
    task automatic make_ready(input logic [7:0] ch);
        int tap;
        for (tap = 0; tap < MAX_TAPS_DEF; tap++)
            if (!coef_set[ch][tap])
                send_item(CMD_WRITE_COEF, ch, 2'(tap), rand_q());
        while (hist_fill[ch] < HIST_DEPTH)
            send_item(CMD_PUSH_HIST, ch, 2'($urandom), rand_q());
    endtask

    task automatic send_random();
        logic [7:0] ch;
        int         roll;
        ch = pick_channel();
        roll = $urandom_range(0, 99);
        if (roll < 5)
            send_item(CMD_UNUSED, 8'($urandom), 2'($urandom), DATA_W'($urandom));
        else if (roll < 15)
            send_item(CMD_WRITE_COEF, ch, 2'($urandom), rand_q());
        else if (roll < 25)
            send_item(CMD_PUSH_HIST, ch, 2'($urandom), rand_q());
        else
        begin
            make_ready(ch);
            send_item(CMD_COMPUTE, ch, 2'($urandom), rand_q());
        end
    endtask

    initial
    begin
        bit paused;
        int seg;
        int tap;
        paused = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        send_idle_pct = 23;
        recv_idle_pct = 84;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // full-scale rows: positive then negative clipping, 4 taps from reset
        for (tap = 0; tap < MAX_TAPS_DEF; tap++)
            send_item(CMD_WRITE_COEF, 8'd0, 2'(tap), Q_MAX);
        repeat (HIST_DEPTH) send_item(CMD_PUSH_HIST, 8'd0, 2'd0, Q_MAX);
        send_item(CMD_COMPUTE, 8'd0, 2'd3, Q_MAX);
        repeat (HIST_DEPTH) send_item(CMD_PUSH_HIST, 8'd0, 2'd3, Q_MIN);
        send_item(CMD_COMPUTE, 8'd0, 2'd0, Q_MIN);

        // rounding at exactly one half LSB, both signs, and just past the negative half
        for (tap = 0; tap < MAX_TAPS_DEF; tap++)
            send_item(CMD_WRITE_COEF, 8'd255, 2'(tap),
                      (tap == MAX_TAPS_DEF - 1) ? 16'sd1 : 16'sd0);
        send_item(CMD_PUSH_HIST, 8'd255, 2'd1, Q_MIN);
        send_item(CMD_PUSH_HIST, 8'd255, 2'd2, 16'sd0);
        send_item(CMD_PUSH_HIST, 8'd255, 2'd3, Q_MAX);
        send_item(CMD_COMPUTE, 8'd255, 2'd0, 16'sd2048);
        send_item(CMD_COMPUTE, 8'd255, 2'd1, -16'sd2048);
        send_item(CMD_COMPUTE, 8'd255, 2'd2, -16'sd2049);
        send_item(CMD_UNUSED, 8'd255, 2'd3, Q_MIN);

        for (seg = 0; seg < NUM_SEGS; seg++)
        begin
            if (seg == 2)
            begin
                send_idle_pct = 84;
                recv_idle_pct = 23;
            end
            if (seg == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_taps(TAPS_CFG_W'(seg_taps[seg]));
            items_sent = 0;
            while (items_sent < SEG_ITEMS)
            begin
                if (seg == 1 && !paused && items_sent >= SEG_ITEMS / 2)
                begin
                    hold_until_drained();
                    paused = 1'b1;
                end
                send_random();
            end
        end

        hold_until_drained();
        repeat (FLUSH_CYCLES) @(negedge clk);
        if (fail_count == 0 && results_due == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== depthwise_causal_conv1d.f =====
+incdir+hw/rtl
hw/rtl/dcc_pkg.sv
hw/rtl/dcc_ram.sv
hw/rtl/depthwise_causal_conv1d.sv
dv/dcc_checker.sv
dv/tb_depthwise_causal_conv1d.sv
